// ===== rtl/ipagc_pkg.sv =====
// Shared types, register indexes and rounding helper for the I/Q power AGC.
`timescale 1ns / 1ps
`default_nettype none
package ipagc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_EMA_COEFF   = 3'd0;
  localparam logic [2:0] REG_TARGET_AMP  = 3'd1;
  localparam logic [2:0] REG_POWER_FLOOR = 3'd2;
  localparam logic [2:0] REG_MAX_GAIN    = 3'd3;
  localparam logic [2:0] REG_MIN_GAIN    = 3'd4;

  // Reset values of the registers and state
  localparam logic [15:0] EMA_COEFF_RST   = 16'd655;
  localparam logic [14:0] TARGET_AMP_RST  = 15'd8192;
  localparam logic [19:0] POWER_FLOOR_RST = 20'd1;
  localparam logic [23:0] MAX_GAIN_RST    = 24'd4194304;
  localparam logic [23:0] MIN_GAIN_RST    = 24'd41;
  localparam logic [23:0] UNITY_GAIN      = 24'd4096;

  // Coefficient of one in Q1.16
  localparam logic [16:0] COEFF_ONE = 17'd65536;

  // Sequencer states
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_II   = 12'b0000_0000_0010,
    ST_QQ   = 12'b0000_0000_0100,
    ST_AV   = 12'b0000_0000_1000,
    ST_CP   = 12'b0000_0001_0000,
    ST_TT   = 12'b0000_0010_0000,
    ST_ST   = 12'b0000_0100_0000,
    ST_RT   = 12'b0000_1000_0000,
    ST_GI   = 12'b0001_0000_0000,
    ST_GQ   = 12'b0010_0000_0000,
    ST_FQ   = 12'b0100_0000_0000,
    ST_OUT  = 12'b1000_0000_0000
  } agc_state_t;

  // Divide / root unit phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DIV  = 3'b010,
    PH_SQR  = 3'b100
  } dsq_phase_t;

  // Scale a Q12.12 x Q1.15 product back to Q1.15, round ties up, saturate.
  // Returns {clip, value}.
  function automatic logic [16:0] round_sat(input logic signed [50:0] p);
    logic signed [51:0] v;
    logic signed [39:0] q;
    v = {p[50], p} + 52'sd2048;
    q = v[51:12];
    if (q > 40'sd32767) begin
      return {1'b1, 16'h7fff};
    end else if (q < -40'sd32768) begin
      return {1'b1, 16'h8000};
    end else begin
      return {1'b0, q[15:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ipagc_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module ipagc_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [17:0] b,
  output logic signed [50:0]      p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== rtl/ipagc_dsq.sv =====
// Iterative divider followed by square root, one shared subtractor, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module ipagc_dsq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [53:0] num,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [26:0]      root
);

  ipagc_pkg::dsq_phase_t phase;
  logic [5:0]  cnt;
  logic [34:0] rem;
  logic [53:0] work;
  logic [34:0] sub_a;
  logic [34:0] sub_b;
  logic [35:0] diff;
  logic        ge;

  // Pick operands of the shared subtractor
  always_comb begin
    if (phase == ipagc_pkg::PH_SQR) begin
      sub_a = {rem[32:0], work[53:52]};
      sub_b = {6'd0, root, 2'b01};
    end else begin
      sub_a = {rem[33:0], work[53]};
      sub_b = {2'd0, den};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[35];
  end

  // Step the quotient, then the root
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ipagc_pkg::PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        ipagc_pkg::PH_IDLE: begin
          if (start) begin
            phase <= ipagc_pkg::PH_DIV;
            cnt   <= 6'd53;
          end
        end
        ipagc_pkg::PH_DIV: begin
          if (cnt == 6'd0) begin
            phase <= ipagc_pkg::PH_SQR;
            cnt   <= 6'd26;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        ipagc_pkg::PH_SQR: begin
          if (cnt == 6'd0) begin
            phase <= ipagc_pkg::PH_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        default: phase <= ipagc_pkg::PH_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (phase)
      ipagc_pkg::PH_IDLE: begin
        if (start) begin
          rem  <= '0;
          work <= num;
        end
      end
      ipagc_pkg::PH_DIV: begin
        work <= {work[52:0], ge};
        if (cnt == 6'd0) begin
          rem  <= '0;
          root <= '0;
        end else begin
          rem <= ge ? diff[34:0] : sub_a;
        end
      end
      ipagc_pkg::PH_SQR: begin
        rem  <= ge ? diff[34:0] : sub_a;
        root <= {root[25:0], ge};
        work <= {work[51:0], 2'b00};
      end
      default: begin
        rem <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/iq_power_agc_unit.sv =====
// Top level of the feedforward RMS automatic gain control for I/Q words.
//
// Each accepted I/Q word updates an exponential average of i*i+q*q and a new
// gain target/sqrt(average+floor), clamped to max_gain and then min_gain, is
// applied to both rails with rounding and 16-bit saturation. One word is in
// work at a time; in_stall is high from acceptance until the result word is
// taken. Each word takes seven passes through the shared multiplier, a
// bit-serial division and a bit-serial square root, plus sequencing. When
// average plus floor is zero the division and square root are skipped and
// max_gain is used. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none
module iq_power_agc_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_i,
  input  wire logic signed [15:0] in_q,
  input  wire logic               block_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic [23:0]             gain_now,
  output logic [31:0]             power_level,
  output logic                    clipped,
  output logic                    block_last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  ipagc_pkg::agc_state_t state;

  logic [15:0] ema_coeff;
  logic [14:0] target_amplitude;
  logic [19:0] power_floor;
  logic [23:0] max_gain;
  logic [23:0] min_gain;

  logic [31:0] avg_power;
  logic [23:0] last_gain;

  logic signed [15:0] xi;
  logic signed [15:0] xq;
  logic               be;
  logic [31:0]        pw;
  logic [47:0]        acc;
  logic [53:0]        num;
  logic [32:0]        den;
  logic               clip_i;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic [48:0]        sum;
  logic [16:0]        rs;
  logic               dsq_start;
  logic               dsq_done;
  logic [26:0]        raw;

  assign in_stall  = (state != ipagc_pkg::ST_IDLE);
  assign out_valid = (state == ipagc_pkg::ST_OUT);
  assign gain_now  = last_gain;
  assign power_level = avg_power;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_coeff        <= ipagc_pkg::EMA_COEFF_RST;
      target_amplitude <= ipagc_pkg::TARGET_AMP_RST;
      power_floor      <= ipagc_pkg::POWER_FLOOR_RST;
      max_gain         <= ipagc_pkg::MAX_GAIN_RST;
      min_gain         <= ipagc_pkg::MIN_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ipagc_pkg::REG_EMA_COEFF:   ema_coeff        <= cfg_data[15:0];
        ipagc_pkg::REG_TARGET_AMP:  target_amplitude <= cfg_data[14:0];
        ipagc_pkg::REG_POWER_FLOOR: power_floor      <= cfg_data[19:0];
        ipagc_pkg::REG_MAX_GAIN:    max_gain         <= cfg_data;
        ipagc_pkg::REG_MIN_GAIN:    min_gain         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select multiplier operands per step
  always_comb begin
    case (state)
      ipagc_pkg::ST_II: begin
        mul_a = 33'(xi);
        mul_b = 18'(xi);
      end
      ipagc_pkg::ST_QQ: begin
        mul_a = 33'(xq);
        mul_b = 18'(xq);
      end
      ipagc_pkg::ST_AV: begin
        mul_a = {1'b0, avg_power};
        mul_b = {1'b0, ipagc_pkg::COEFF_ONE - {1'b0, ema_coeff}};
      end
      ipagc_pkg::ST_CP: begin
        mul_a = {1'b0, pw};
        mul_b = {2'b00, ema_coeff};
      end
      ipagc_pkg::ST_TT: begin
        mul_a = {18'd0, target_amplitude};
        mul_b = {3'd0, target_amplitude};
      end
      ipagc_pkg::ST_GI: begin
        mul_a = {9'd0, last_gain};
        mul_b = 18'(xi);
      end
      ipagc_pkg::ST_GQ: begin
        mul_a = {9'd0, last_gain};
        mul_b = 18'(xq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ipagc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign sum       = {1'b0, acc} + {1'b0, prod[47:0]} + 49'd32768;
  assign den       = {1'b0, avg_power} + {13'd0, power_floor};
  assign num       = {prod[29:0], 24'd0};
  assign dsq_start = (state == ipagc_pkg::ST_ST) && (den != 33'd0);
  assign rs        = ipagc_pkg::round_sat(prod);

  ipagc_dsq u_dsq (
    .clk   (clk),
    .rst   (rst),
    .start (dsq_start),
    .num   (num),
    .den   (den),
    .done  (dsq_done),
    .root  (raw)
  );

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipagc_pkg::ST_IDLE;
      avg_power <= '0;
      last_gain <= ipagc_pkg::UNITY_GAIN;
    end else begin
      case (state)
        ipagc_pkg::ST_IDLE: begin
          if (in_valid) begin
            state <= ipagc_pkg::ST_II;
          end
        end
        ipagc_pkg::ST_II: state <= ipagc_pkg::ST_QQ;
        ipagc_pkg::ST_QQ: state <= ipagc_pkg::ST_AV;
        ipagc_pkg::ST_AV: state <= ipagc_pkg::ST_CP;
        ipagc_pkg::ST_CP: state <= ipagc_pkg::ST_TT;
        ipagc_pkg::ST_TT: begin
          avg_power <= sum[47:16];
          state     <= ipagc_pkg::ST_ST;
        end
        ipagc_pkg::ST_ST: begin
          if (den == 33'd0) begin
            last_gain <= max_gain;
            state     <= ipagc_pkg::ST_GI;
          end else begin
            state <= ipagc_pkg::ST_RT;
          end
        end
        ipagc_pkg::ST_RT: begin
          if (dsq_done) begin
            if (raw > {3'd0, max_gain}) begin
              last_gain <= max_gain;
            end else if (raw < {3'd0, min_gain}) begin
              last_gain <= min_gain;
            end else begin
              last_gain <= raw[23:0];
            end
            state <= ipagc_pkg::ST_GI;
          end
        end
        ipagc_pkg::ST_GI: state <= ipagc_pkg::ST_GQ;
        ipagc_pkg::ST_GQ: state <= ipagc_pkg::ST_FQ;
        ipagc_pkg::ST_FQ: state <= ipagc_pkg::ST_OUT;
        ipagc_pkg::ST_OUT: begin
          if (!out_stall) begin
            state <= ipagc_pkg::ST_IDLE;
          end
        end
        default: state <= ipagc_pkg::ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ipagc_pkg::ST_IDLE: begin
        xi <= in_i;
        xq <= in_q;
        be <= block_end;
      end
      ipagc_pkg::ST_QQ: pw  <= prod[31:0];
      ipagc_pkg::ST_AV: pw  <= pw + prod[31:0];
      ipagc_pkg::ST_CP: acc <= prod[47:0];
      ipagc_pkg::ST_GQ: begin
        out_i  <= rs[15:0];
        clip_i <= rs[16];
      end
      ipagc_pkg::ST_FQ: begin
        out_q      <= rs[15:0];
        clipped    <= clip_i | rs[16];
        block_last <= be;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // Root result arrives only while the sequencer waits for it
  a_done_in_rt: assert property (@(posedge clk) disable iff (rst)
    dsq_done |-> (state == ipagc_pkg::ST_RT))
    else $error("root result outside wait state");

  // A stalled result word holds its values
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_i) && $stable(out_q)
      && $stable(gain_now) && $stable(power_level)))
    else $error("result word changed while stalled");

  // Input stays stalled while a result word waits
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result word pending");
`endif

endmodule
`default_nettype wire
